FILE: sv/rcst_pkg.sv
// Package for the reference-counted subscription table: types, codes and defaults.
`timescale 1ns / 1ps

package rcst_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 256;
  localparam logic [15:0] FILT_ID_RESET   = 16'd2056;
  localparam logic [15:0] USE_COUNT_MAX   = 16'hFFFF;

  typedef enum logic {
    OP_SUBSCRIBE   = 1'b0,
    OP_UNSUBSCRIBE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ACT_FILTERED = 3'd0,
    ACT_FULL     = 3'd1,
    ACT_RAISED   = 3'd2,
    ACT_ADDED    = 3'd3,
    ACT_NOTFOUND = 3'd4,
    ACT_LOWERED  = 3'd5,
    ACT_REMOVED  = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH_RD,
    ST_SEARCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] qos;
    logic [15:0] cnt;
  } entry_t;

endpackage

FILE: sv/refcounted_subscription_table.sv
// Top level of the reference-counted subscription table: sequencer, datapath and entry RAM.
//
//   channel   | direction | handshake                     | payload
//   ----------+-----------+-------------------------------+--------------------------------
//   request   | in        | start && !busy                | opcode_i, msg_id_i, qos_i
//   result    | out       | result_valid_o (one cycle)    | action_o, announce_msg_id_o,
//             |           |                               | announce_qos_o, entry_count_o
//   config    | in        | cfg_valid_i && cfg_ready_o    | cfg_data_i (filtered_msg_id)
//
// A request walks the table one entry at a time through the single RAM read port
// (address, then compare), and a removal moves each higher entry down one place
// (read, then write); filtered and full subscribes skip the search. Reset empties the
// table at once, the RAM is not cleared. The result cannot be stalled; busy stays high
// until it has been shown.
`timescale 1ns / 1ps

module refcounted_subscription_table import rcst_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES),
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [15:0] msg_id_i,
  input  logic [15:0] qos_i,
  output logic        result_valid_o,
  output logic [2:0]  action_o,
  output logic [15:0] announce_msg_id_o,
  output logic [15:0] announce_qos_o,
  output logic [8:0]  entry_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [15:0]      filt_q;
  opcode_e          op_q;
  logic [15:0]      id_q, qos_q;
  action_e          act_q, act_d;
  logic [15:0]      ann_id_q, ann_id_d;
  logic [15:0]      ann_qos_q, ann_qos_d;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  logic             accept;
  logic             hit;
  logic [CNT_W:0]   idx_next;
  logic [CNT_W+8:0] used_ext;

  assign accept   = start && !busy;
  assign hit      = (ram_rdata.id == id_q);
  assign idx_next = {1'b0, idx_q} + {{CNT_W{1'b0}}, 1'b1};
  assign used_ext = {9'd0, used_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_SUBSCRIBE &&
              (msg_id_i == filt_q || used_q >= MAX_CNT)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SEARCH_RD;
          end
        end
      end
      ST_SEARCH_RD: begin
        state_d = (idx_q == used_q) ? ST_DONE : ST_SEARCH_CMP;
      end
      ST_SEARCH_CMP: begin
        if (!hit) begin
          state_d = ST_SEARCH_RD;
        end else if (op_q == OP_UNSUBSCRIBE && ram_rdata.cnt <= 16'd1) begin
          state_d = ST_SHIFT_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SHIFT_RD: begin
        state_d = (idx_next >= {1'b0, used_q}) ? ST_DONE : ST_SHIFT_WR;
      end
      ST_SHIFT_WR: state_d = ST_SHIFT_RD;
      ST_DONE:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    idx_d     = idx_q;
    used_d    = used_q;
    act_d     = act_q;
    ann_id_d  = ann_id_q;
    ann_qos_d = ann_qos_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_q[IDX_W-1:0];
    ram_raddr = idx_q[IDX_W-1:0];
    ram_wdata = ram_rdata;
    unique case (state_q)
      ST_IDLE: begin
        idx_d     = '0;
        ann_id_d  = '0;
        ann_qos_d = '0;
        act_d     = (msg_id_i == filt_q) ? ACT_FILTERED : ACT_FULL;
      end
      ST_SEARCH_RD: begin
        if (idx_q == used_q) begin
          if (op_q == OP_SUBSCRIBE) begin
            // Not present: append at the end of the table.
            ram_we        = 1'b1;
            ram_wdata.id  = id_q;
            ram_wdata.qos = qos_q;
            ram_wdata.cnt = 16'd1;
            used_d        = used_q + CNT_W'(1);
            act_d         = ACT_ADDED;
            ann_id_d      = id_q;
            ann_qos_d     = qos_q;
          end else begin
            act_d = ACT_NOTFOUND;
          end
        end else begin
          ram_re = 1'b1;
        end
      end
      ST_SEARCH_CMP: begin
        if (!hit) begin
          idx_d = idx_next[CNT_W-1:0];
        end else if (op_q == OP_SUBSCRIBE) begin
          ram_we = 1'b1;
          if (ram_rdata.cnt != USE_COUNT_MAX) begin
            ram_wdata.cnt = ram_rdata.cnt + 16'd1;
          end
          act_d = ACT_RAISED;
        end else if (ram_rdata.cnt > 16'd1) begin
          ram_we        = 1'b1;
          ram_wdata.cnt = ram_rdata.cnt - 16'd1;
          act_d         = ACT_LOWERED;
        end else begin
          act_d     = ACT_REMOVED;
          ann_id_d  = ram_rdata.id;
          ann_qos_d = ram_rdata.qos;
        end
      end
      ST_SHIFT_RD: begin
        if (idx_next >= {1'b0, used_q}) begin
          used_d = used_q - CNT_W'(1);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_next[IDX_W-1:0];
        end
      end
      ST_SHIFT_WR: begin
        ram_we = 1'b1;
        idx_d  = idx_next[CNT_W-1:0];
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      filt_q  <= FILT_ID_RESET;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (cfg_valid_i && cfg_ready_o) begin
        filt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    act_q     <= act_d;
    ann_id_q  <= ann_id_d;
    ann_qos_q <= ann_qos_d;
    if (accept) begin
      op_q  <= opcode_e'(opcode_i);
      id_q  <= msg_id_i;
      qos_q <= qos_i;
    end
  end

  rcst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy              = (state_q != ST_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign result_valid_o    = (state_q == ST_DONE);
  assign action_o          = act_q;
  assign announce_msg_id_o = ann_id_q;
  assign announce_qos_o    = ann_qos_q;
  assign entry_count_o     = used_ext[8:0];

endmodule

FILE: sv/rcst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rcst_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
